@@ rtl/http_response_header_parser_defines.svh @@
// ---------------------------------------------------------------------------
// http response header parser assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ---------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// condition in the same cycle
`define HRHP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition in the following cycle
`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hrhp_pkg.sv @@
// ---------------------------------------------------------------------------
// hrhp_pkg
// types, character codes and lookup functions of the http response parser
// ---------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

   // field widths of the result item
   localparam int CODE_W = 10;
   localparam int CL_W   = 24;

   // character codes
   localparam logic [7:0] CHAR_SP   = 8'h20;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // label and status limits
   localparam logic [3:0] LABEL_LEN   = 4'd15;
   localparam logic [2:0] OK_LEN      = 3'd3;
   localparam logic [2:0] CODE_CHARS_MAX = 3'd4;
   localparam logic [13:0] CODE_MAX   = 14'd999;
   localparam logic [1:0] NEWLINE_END = 2'd3;

   // parse phase
   typedef enum logic [2:0] {
      PH_PRE    = 3'd0,
      PH_STATUS = 3'd1,
      PH_HEADER = 3'd2,
      PH_DROP   = 3'd3,
      PH_BODY   = 3'd4
   } phase_type;

   // result item payload
   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] status_code;
      logic              status_ok;
      logic [CL_W-1:0]   content_length;
      logic [7:0]        body_byte;
      logic              last;
   } rsp_payload_type;

   // characters of "Content-Length:"
   function automatic logic [7:0] label_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3A; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // characters of "200"
   function automatic logic [7:0] ok_char(input logic [1:0] pos);
      logic [7:0] ch;
      unique case (pos)
         2'd0:    ch = 8'h32;
         default: ch = 8'h30;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

@@ rtl/hrhp_ifs.sv @@
// ---------------------------------------------------------------------------
// hrhp channel interfaces
// valid/ready channels for the byte stream and for result items
// ---------------------------------------------------------------------------
`default_nettype none

// response byte stream
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// summary and body result items
interface hrhp_rsp_if import hrhp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [CODE_W-1:0] status_code;
   logic              status_ok;
   logic [CL_W-1:0]   content_length;
   logic [7:0]        body_byte;
   logic              last;

   modport source (output valid, output kind, output status_code, output status_ok,
                   output content_length, output body_byte, output last, input ready);
   modport sink (input valid, input kind, input status_code, input status_ok,
                 input content_length, input body_byte, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/http_response_header_parser.sv @@
// path: the accepted byte is held in the input byte register, and its result item, if any, in the result register
// throughput: one byte per cycle, set by the single parse step between
// the input byte register and the result register; a result item held
// on rsp_ch stalls the input
// reset: synchronous, parser returns to waiting for the status line,
// both pipeline registers empty
// ---------------------------------------------------------------------------
// http_response_header_parser
// parses status code and content length from a response header, emits a
// summary item, then for a 200 response with a nonzero length passes the body bytes through
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_response_header_parser_defines.svh"

module http_response_header_parser
   import hrhp_pkg::*;
#(
   parameter int LEN_BITS = 24
) (
   input  wire           clock,
   input  wire           reset,
   hrhp_req_if.sink      req_ch,
   hrhp_rsp_if.source    rsp_ch
);

   localparam int AW = LEN_BITS + 4;

   // input byte register
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;

   // parse state
   phase_type           phase_ff, phase_in;
   logic [1:0]          newline_run_ff, newline_run_in;
   logic [CODE_W-1:0]   code_value_ff, code_value_in;
   logic [2:0]          code_chars_ff, code_chars_in;
   logic                code_is_200_ff, code_is_200_in;
   logic [3:0]          match_pos_ff, match_pos_in;
   logic                token_mismatch_ff, token_mismatch_in;
   logic                label_seen_ff, label_seen_in;
   logic                number_active_ff, number_active_in;
   logic                length_done_ff, length_done_in;
   logic [LEN_BITS-1:0] length_acc_ff, length_acc_in;
   logic [LEN_BITS-1:0] body_left_ff, body_left_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     out_ff, out_in;

   // step signals
   logic                fire;
   logic                emit;
   logic [7:0]          ch;
   logic                is_digit;
   logic                is_sep;
   logic                is_eol;
   logic                nonempty;
   logic                ok;
   logic [LEN_BITS-1:0] len;
   logic [LEN_BITS-1:0] body_dec;
   logic [13:0]         code_wide;
   logic [CODE_W-1:0]   code_next;
   logic [AW-1:0]       acc_wide;
   logic [LEN_BITS-1:0] acc_next;

   // handshake
   assign fire         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || fire;

   // character classes and decimal accumulate
   always_comb begin
      ch        = in_byte_ff;
      is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      is_sep    = (ch == CHAR_SP) || (ch == CHAR_LF);
      is_eol    = (ch == CHAR_CR) || (ch == CHAR_LF);
      nonempty  = (match_pos_ff != 4'd0) || token_mismatch_ff;
      code_wide = (14'(code_value_ff) << 3) + (14'(code_value_ff) << 1) + 14'(ch[3:0]);
      code_next = (code_wide > CODE_MAX) ? CODE_W'(CODE_MAX) : code_wide[CODE_W-1:0];
      acc_wide  = (AW'(length_acc_ff) << 3) + (AW'(length_acc_ff) << 1) + AW'(ch[3:0]);
      acc_next  = (|acc_wide[AW-1:LEN_BITS]) ? '1 : acc_wide[LEN_BITS-1:0];
      body_dec  = (body_left_ff != '0) ? body_left_ff - LEN_BITS'(1) : '0;
   end

   // parse step
   always_comb begin
      phase_in          = phase_ff;
      newline_run_in    = newline_run_ff;
      code_value_in     = code_value_ff;
      code_chars_in     = code_chars_ff;
      code_is_200_in    = code_is_200_ff;
      match_pos_in      = match_pos_ff;
      token_mismatch_in = token_mismatch_ff;
      label_seen_in     = label_seen_ff;
      number_active_in  = number_active_ff;
      length_done_in    = length_done_ff;
      length_acc_in     = length_acc_ff;
      body_left_in      = body_left_ff;
      emit              = 1'b0;
      ok                = 1'b0;
      len               = '0;
      out_in            = out_ff;

      if (fire) begin
         unique case (phase_ff)
            // drop the byte after the header
            PH_DROP: begin
               phase_in = (body_left_ff == '0) ? PH_PRE : PH_BODY;
            end
            // body pass-through
            PH_BODY: begin
               body_left_in = body_dec;
               emit         = 1'b1;
               out_in       = '0;
               out_in.kind      = 1'b1;
               out_in.body_byte = ch;
               out_in.last      = (body_dec == '0);
               if (body_dec == '0) begin
                  phase_in = PH_PRE;
               end
            end
            default: begin
               // status line
               if (phase_ff == PH_PRE) begin
                  if (ch == CHAR_SP) begin
                     phase_in       = PH_STATUS;
                     code_is_200_in = 1'b1;
                     code_chars_in  = '0;
                     code_value_in  = '0;
                  end
               end else if (phase_ff == PH_STATUS) begin
                  if (ch == CHAR_SP) begin
                     phase_in = PH_HEADER;
                  end else begin
                     if (code_chars_ff < OK_LEN && ch != ok_char(code_chars_ff[1:0])) begin
                        code_is_200_in = 1'b0;
                     end
                     if (code_chars_ff < CODE_CHARS_MAX) begin
                        code_chars_in = code_chars_ff + 3'd1;
                     end
                     if (is_digit) begin
                        code_value_in = code_next;
                     end
                  end
               end

               // token matcher for the length label and its value
               if (is_sep) begin
                  if (label_seen_ff && !length_done_ff && nonempty) begin
                     length_done_in   = 1'b1;
                     number_active_in = 1'b0;
                  end else if (!token_mismatch_ff && match_pos_ff == LABEL_LEN &&
                               !length_done_ff) begin
                     label_seen_in = 1'b1;
                     length_acc_in = '0;
                  end
                  match_pos_in      = '0;
                  token_mismatch_in = 1'b0;
               end else begin
                  if (label_seen_ff && !length_done_ff) begin
                     if (!nonempty) begin
                        number_active_in = is_digit;
                        length_acc_in    = is_digit ? LEN_BITS'(ch[3:0]) : '0;
                     end else if (number_active_ff) begin
                        if (is_digit) begin
                           length_acc_in = acc_next;
                        end else begin
                           number_active_in = 1'b0;
                        end
                     end
                  end
                  if (!token_mismatch_ff) begin
                     if (match_pos_ff < LABEL_LEN && ch == label_char(match_pos_ff)) begin
                        match_pos_in = match_pos_ff + 4'd1;
                     end else begin
                        token_mismatch_in = 1'b1;
                     end
                  end
               end

               // end of header detection
               newline_run_in = is_eol ? newline_run_ff + 2'd1 : '0;

               if (newline_run_in == NEWLINE_END) begin
                  ok   = (phase_in == PH_HEADER) && code_is_200_in &&
                         (code_chars_in == OK_LEN);
                  len  = length_done_in ? length_acc_in : '0;
                  emit = 1'b1;
                  out_in                = '0;
                  out_in.status_code    = code_value_in;
                  out_in.status_ok      = ok;
                  out_in.content_length = CL_W'(len);
                  out_in.last           = !(ok && len != '0);
                  // start over for the next response
                  phase_in          = ok ? PH_DROP : PH_PRE;
                  newline_run_in    = '0;
                  code_value_in     = '0;
                  code_chars_in     = '0;
                  code_is_200_in    = 1'b0;
                  match_pos_in      = '0;
                  token_mismatch_in = 1'b0;
                  label_seen_in     = 1'b0;
                  number_active_in  = 1'b0;
                  length_done_in    = 1'b0;
                  length_acc_in     = '0;
                  body_left_in      = ok ? len : '0;
               end
            end
         endcase
      end
   end

   // pipeline valid flags
   always_comb begin
      in_valid_in  = (req_ch.valid && req_ch.ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      out_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   // control and parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         phase_ff          <= PH_PRE;
         newline_run_ff    <= '0;
         code_value_ff     <= '0;
         code_chars_ff     <= '0;
         code_is_200_ff    <= 1'b0;
         match_pos_ff      <= '0;
         token_mismatch_ff <= 1'b0;
         label_seen_ff     <= 1'b0;
         number_active_ff  <= 1'b0;
         length_done_ff    <= 1'b0;
         length_acc_ff     <= '0;
         body_left_ff      <= '0;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         phase_ff          <= phase_in;
         newline_run_ff    <= newline_run_in;
         code_value_ff     <= code_value_in;
         code_chars_ff     <= code_chars_in;
         code_is_200_ff    <= code_is_200_in;
         match_pos_ff      <= match_pos_in;
         token_mismatch_ff <= token_mismatch_in;
         label_seen_ff     <= label_seen_in;
         number_active_ff  <= number_active_in;
         length_done_ff    <= length_done_in;
         length_acc_ff     <= length_acc_in;
         body_left_ff      <= body_left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      out_ff <= out_in;
   end

   // result port
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_ff.kind;
   assign rsp_ch.status_code    = out_ff.status_code;
   assign rsp_ch.status_ok      = out_ff.status_ok;
   assign rsp_ch.content_length = out_ff.content_length;
   assign rsp_ch.body_byte      = out_ff.body_byte;
   assign rsp_ch.last           = out_ff.last;

   // checks
   `HRHP_ASSERT_SAME(a_body_left_nonzero, clock, reset, phase_ff == PH_BODY,
                     body_left_ff != '0, "body phase with no bytes left")
   `HRHP_ASSERT_SAME(a_newline_run_cleared, clock, reset, 1'b1,
                     newline_run_ff != NEWLINE_END, "newline run not cleared at header end")
   `HRHP_ASSERT_NEXT(a_summary_to_drop, clock, reset,
                     fire && emit && !out_in.kind && !out_in.last,
                     phase_ff == PH_DROP, "summary with body did not enter drop phase")

endmodule

`default_nettype wire
